[design/lsoa_pkg.sv]
// Types and codes shared by the stack controller, datapath and top level.
// No dependencies.
package lsoa_pkg;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_CHANGE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    localparam int unsigned WordW  = 32;
    localparam int unsigned OffW   = 7;
    localparam int unsigned IndexW = 7;
    localparam int unsigned FillW  = 8;

    typedef struct packed {
        opcode_t                   opcode;
        logic signed [WordW-1:0]   value;
        logic [OffW-1:0]           offset;
    } req_t;

    typedef struct packed {
        logic signed [WordW-1:0]   data;
        status_t                   status;
        logic [IndexW-1:0]         entry_index;
        logic [FillW-1:0]          fill_count;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture request
        logic exec;   // decide, touch storage, update count
    } cmd_t;

endpackage

[design/lsoa_ram.sv]
// Generic single-port RAM, one write or one read per cycle, registered read data.
// No dependencies.
module lsoa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

[design/lsoa_ctrl.sv]
// Stack controller: sequences each request through execute and result cycles.
// Depends on lsoa_pkg.
module lsoa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    output lsoa_pkg::cmd_t cmd
);
    import lsoa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    state_t state_reg;
    logic   done_reg;
    logic   accept;

    assign busy   = (state_reg == S_EXEC);
    assign accept = start && !busy;
    assign done   = done_reg;

    assign cmd.load = accept;
    assign cmd.exec = (state_reg == S_EXEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE, S_RESP:
                begin
                    state_reg <= accept ? S_EXEC : S_IDLE;
                end
                S_EXEC:
                begin
                    state_reg <= S_RESP;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> done)
        else $error("result strobe missing after execute");
    a_done_only_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> !done)
        else $error("result strobe without execute");
    a_accept_leads_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> cmd.exec)
        else $error("accepted request not executed");
`endif

endmodule

[design/lsoa_dpath.sv]
// Stack datapath: request register, fill count, bounds checks, RAM access, result fields.
// Depends on lsoa_pkg and lsoa_ram.
module lsoa_dpath #(
    parameter int unsigned DEPTH = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    input  lsoa_pkg::cmd_t cmd,
    input  lsoa_pkg::req_t req,
    input  logic           done,
    output lsoa_pkg::rsp_t result
);
    import lsoa_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned MW = (CW > OffW) ? CW : OffW;
    localparam int unsigned IW = (AW > IndexW) ? AW : IndexW;
    localparam int unsigned FW = (CW > FillW) ? CW : FillW;

    req_t             req_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    status_t          status_reg;
    status_t          status_next;
    logic [IndexW-1:0] idx_reg;
    logic [FillW-1:0] fill_reg;
    logic             rd_reg;

    logic             is_empty;
    logic             is_full;
    logic             off_bad;
    logic [MW-1:0]    off_idx;
    logic [AW-1:0]    addr;
    logic             ram_we;
    logic             ram_re;
    logic             ok;
    logic [WordW-1:0] rdata;
    logic [IW-1:0]    idx_w;
    logic [FW-1:0]    fill_w;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(DEPTH));
    assign off_bad  = (MW'(req_reg.offset) >= MW'(count_reg));
    // storage index of the entry "offset" below the top
    assign off_idx  = MW'(count_reg) - MW'(1) - MW'(req_reg.offset);

    always_comb
    begin
        status_next = ST_OK;
        count_next  = count_reg;
        addr        = off_idx[AW-1:0];
        unique case (req_reg.opcode)
            OP_PUSH:
            begin
                addr = count_reg[AW-1:0];
                if (is_full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            OP_POP:
            begin
                // top entry; wraps correctly when the stack is full
                addr = count_reg[AW-1:0] - AW'(1);
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            OP_PEEK, OP_CHANGE:
            begin
                priority if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (off_bad)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    status_next = ST_OK;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign ok     = (status_next == ST_OK);
    assign ram_we = cmd.exec && ok &&
                    ((req_reg.opcode == OP_PUSH) || (req_reg.opcode == OP_CHANGE));
    assign ram_re = cmd.exec && ok &&
                    ((req_reg.opcode == OP_POP) || (req_reg.opcode == OP_PEEK));

    assign idx_w  = ok ? IW'(addr) : '0;
    assign fill_w = FW'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.exec)
        begin
            status_reg            <= status_next;
            idx_reg               <= idx_w[IndexW-1:0];
            rd_reg                <= ram_re;
            fill_reg              <= fill_w[FillW-1:0];
        end
    end

    lsoa_ram #(
        .WIDTH (WordW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (addr),
        .wdata (req_reg.value),
        .rdata (rdata)
    );

    assign result.data        = (done && rd_reg) ? signed'(rdata) : '0;
    assign result.status      = status_reg;
    assign result.entry_index = idx_reg;
    assign result.fill_count  = fill_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> $stable(count_reg))
        else $error("fill count moved outside execute");
    a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("RAM read and write in one cycle");
`endif

endmodule

[design/lifo_stack_with_offset_access_top.sv]
// LIFO stack with offset access. A request is taken when start is high and busy low;
// done is high in the cycle after the execute cycle. Each request has an execute cycle
// on the single storage RAM port, then a result cycle for the RAM's registered read.
// busy is high only in the execute cycle, so a new request is taken during done.
// Reset (rst_n, async, active low) empties the stack; storage is not cleared.
// Results cannot be stalled. Depends on lsoa_pkg, lsoa_ctrl, lsoa_dpath, lsoa_ram.
module lifo_stack_with_offset_access_top #(
    parameter int unsigned DEPTH = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  lsoa_pkg::req_t req,
    output logic           done,
    output lsoa_pkg::rsp_t result
);
    import lsoa_pkg::*;

    cmd_t cmd;

    lsoa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    lsoa_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .req    (req),
        .done   (done),
        .result (result)
    );

endmodule

[test/stack_result_checker.sv]
// Result checker for the LIFO stack with offset access: mirrors the stack on every
// accepted request and compares each strobed result field by field.
// Depends on lsoa_pkg.
module stack_result_checker #(
    parameter int unsigned DEPTH = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  lsoa_pkg::req_t req,
    input  logic           done,
    input  lsoa_pkg::rsp_t result,
    output int unsigned    failures,
    output int unsigned    pending
);
    import lsoa_pkg::*;

    logic signed [WordW-1:0] stack_words [DEPTH];
    int unsigned             stack_fill;
    rsp_t                    expected_results [$];
    int unsigned             mismatch_count;
    int unsigned             result_number;

    assign failures = mismatch_count;

    initial
    begin
        mismatch_count = 0;
        result_number  = 0;
        stack_fill     = 0;
        pending        = 0;
    end

    task automatic report_mismatch(input string what);
        // keep the log bounded when everything goes wrong
        if (mismatch_count < 100)
            $display("mismatch at result %0d, t=%0t: %s", result_number, $time, what);
        mismatch_count++;
    endtask

    // Applies one request to the mirrored stack and returns its result.
    function automatic rsp_t predict_stack_op(input req_t r);
        rsp_t        o;
        int unsigned idx;
        o        = '0;
        o.status = ST_OK;
        case (r.opcode)
            OP_PUSH:
            begin
                if (stack_fill >= DEPTH)
                    o.status = ST_OVERFLOW;
                else
                begin
                    idx = stack_fill;
                    stack_words[idx] = r.value;
                    stack_fill++;
                    o.entry_index = idx[IndexW-1:0];
                end
            end
            OP_POP:
            begin
                if (stack_fill == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    idx = stack_fill - 1;
                    stack_fill = idx;
                    o.data = stack_words[idx];
                    o.entry_index = idx[IndexW-1:0];
                end
            end
            default:
            begin
                if (stack_fill == 0)
                    o.status = ST_EMPTY;
                else if (r.offset >= stack_fill)
                    o.status = ST_RANGE;
                else
                begin
                    idx = stack_fill - 1 - r.offset;
                    o.entry_index = idx[IndexW-1:0];
                    if (r.opcode == OP_PEEK)
                        o.data = stack_words[idx];
                    else
                        stack_words[idx] = r.value;
                end
            end
        endcase
        o.fill_count = stack_fill[FillW-1:0];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_rsp;
        if (!rst_n)
        begin
            expected_results.delete();
            stack_fill = 0;
            pending <= 0;
        end
        else
        begin
            if ($isunknown(done))
                report_mismatch("done strobe is unknown");
            else if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    exp_rsp = expected_results.pop_front();
                    if (result.data !== exp_rsp.data)
                        report_mismatch($sformatf("data %0d, expected %0d",
                                                  result.data, exp_rsp.data));
                    if (result.status !== exp_rsp.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  result.status, exp_rsp.status));
                    if (result.entry_index !== exp_rsp.entry_index)
                        report_mismatch($sformatf("entry_index %0d, expected %0d",
                                                  result.entry_index,
                                                  exp_rsp.entry_index));
                    if (result.fill_count !== exp_rsp.fill_count)
                        report_mismatch($sformatf("fill_count %0d, expected %0d",
                                                  result.fill_count,
                                                  exp_rsp.fill_count));
                end
                result_number++;
            end
            if (start && !busy)
                expected_results.push_back(predict_stack_op(req));
            pending <= expected_results.size();
        end
    end

endmodule

[test/tb_lifo_stack_with_offset_access_top.sv]
// Testbench top for the LIFO stack with offset access: drives directed and random
// requests in bursts and gives the verdict. Depends on lsoa_pkg,
// lifo_stack_with_offset_access_top and stack_result_checker.
module tb_lifo_stack_with_offset_access_top;
    import lsoa_pkg::*;

    localparam int unsigned DEPTH        = 128;
    localparam int unsigned RandomItems  = 1930;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN,
        MIX_PUSH_ONLY
    } op_mix_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        done;
    rsp_t        result;
    int unsigned failures;
    int unsigned pending;

    int unsigned fill_est;
    int unsigned burst_left;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    lifo_stack_with_offset_access_top #(.DEPTH(DEPTH)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    stack_result_checker #(.DEPTH(DEPTH)) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .result   (result),
        .failures (failures),
        .pending  (pending)
    );

    // Presents one request and waits for the edge that takes it; start stays high
    // within a burst, and at a burst's end the task drops start for a random gap.
    task automatic issue(input opcode_t op, input logic signed [WordW-1:0] v,
                         input logic [OffW-1:0] off);
        int unsigned gap;
        start      <= 1'b1;
        req.opcode <= op;
        req.value  <= v;
        req.offset <= off;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        if (op == OP_PUSH && fill_est < DEPTH)
            fill_est++;
        else if (op == OP_POP && fill_est > 0)
            fill_est--;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            // some bursts are long stretches with no idling at all
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds off new requests until every outstanding result has come back.
    task automatic wait_all_returned();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [WordW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OffW-1:0] pick_offset();
        if (fill_est == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, 127);
        return $urandom_range(0, fill_est - 1);
    endfunction

    function automatic opcode_t pick_op(input op_mix_t mix);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_PUSH_ONLY: return OP_PUSH;
            MIX_FILL:
                if (r < 70)      return OP_PUSH;
                else if (r < 80) return OP_POP;
                else if (r < 90) return OP_PEEK;
                else             return OP_CHANGE;
            MIX_DRAIN:
                if (r < 65)      return OP_POP;
                else if (r < 75) return OP_PUSH;
                else if (r < 88) return OP_PEEK;
                else             return OP_CHANGE;
            default:
                return opcode_t'($urandom_range(0, 3));
        endcase
    endfunction

    initial
    begin
        op_mix_t     mix;
        int unsigned seg_left;
        int unsigned sent;

        rst_n      = 1'b0;
        start      = 1'b0;
        req        = '0;
        fill_est   = 0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack, extremes, offsets at and past the top of the fill
        issue(OP_POP,    32'sd0,         7'd0);
        issue(OP_PEEK,   32'sd0,         7'd0);
        issue(OP_CHANGE, 32'sd5,         7'd0);
        issue(OP_PUSH,   32'sh7FFF_FFFF, 7'd0);
        issue(OP_PUSH,   32'sh8000_0000, 7'd0);
        issue(OP_PUSH,   32'sd0,         7'd0);
        issue(OP_PUSH,   -32'sd1,        7'd127);
        issue(OP_PEEK,   32'sd0,         7'd0);
        issue(OP_PEEK,   32'sd0,         7'd3);
        issue(OP_PEEK,   32'sd0,         7'd4);
        issue(OP_PEEK,   32'sd0,         7'd127);
        issue(OP_CHANGE, 32'sh5555_5555, 7'd0);
        issue(OP_CHANGE, 32'shAAAA_AAAA, 7'd3);
        issue(OP_CHANGE, 32'sd9,         7'd4);
        issue(OP_CHANGE, 32'sd9,         7'd127);
        issue(OP_PEEK,   32'sd0,         7'd0);
        issue(OP_PEEK,   32'sd0,         7'd3);
        issue(OP_POP,    32'sd0,         7'd0);
        issue(OP_POP,    32'sd0,         7'd0);
        issue(OP_POP,    32'sd0,         7'd0);
        issue(OP_POP,    32'sd0,         7'd0);
        issue(OP_POP,    32'sd0,         7'd0);
        wait_all_returned();

        // first segment fills the stack past full so overflow is always hit
        mix      = MIX_PUSH_ONLY;
        seg_left = DEPTH + 4;
        for (sent = 0; sent < RandomItems; sent++)
        begin
            if (seg_left == 0)
            begin
                mix      = op_mix_t'($urandom_range(0, 2));
                seg_left = $urandom_range(20, 180);
            end
            seg_left--;
            if (sent == RandomItems / 2)
                wait_all_returned();
            issue(pick_op(mix), pick_value(), pick_offset());
        end

        wait_all_returned();
        repeat (6) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
design/lsoa_pkg.sv
design/lsoa_ram.sv
design/lsoa_ctrl.sv
design/lsoa_dpath.sv
design/lifo_stack_with_offset_access_top.sv
test/stack_result_checker.sv
test/tb_lifo_stack_with_offset_access_top.sv
